[rtl/ksw_pkg.sv]
// Shared types and constants for the keyed sliding-window rate limiter.
// No dependencies; imported by keyed_sliding_window_rate_limiter_top.
`default_nettype none

package ksw_pkg;

   // request / response payloads
   typedef struct packed {
      logic        operation;
      logic [3:0]  key_index;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [3:0] log_count;
   } rsp_type;

   // operation codes
   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // register file
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REQUESTS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 1'd1;

   localparam logic [3:0]  RST_MAX_REQUESTS  = 4'd5;
   localparam logic [30:0] RST_WINDOW_LENGTH = 31'd1000;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_READ,
      ST_AGE,
      ST_DECIDE,
      ST_DONE
   } state_type;

endpackage : ksw_pkg

`default_nettype wire

[rtl/ksw_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
// No package dependencies.
`default_nettype none

module ksw_ram #(
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 8
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : ksw_ram

`default_nettype wire

[rtl/keyed_sliding_window_rate_limiter_top.sv]
// Keyed sliding-window-log rate limiter, top level.
// Depends on ksw_pkg and ksw_ram.
//
// Each key owns a circular log of up to MAX_LOG admitted timestamps held in
// a stamp RAM, plus a per-key {count, oldest slot} word in a small metadata
// RAM. One item is worked at a time by a sequencer around a single shared
// age unit (one 32-bit subtract and compare against window_length): the
// sequencer reads the key's metadata, then walks the log from its oldest
// entry stamp by stamp (RAM read, age compare), drops expired ones,
// and stops at the first live one. It then checks the count against
// min(max_requests, MAX_LOG), appends now_time if there is room, and writes
// the metadata back. A clear instead writes zero metadata for its key, and
// neither a clear nor an out-of-range key walks the log. req_stall is low
// only while the sequencer idles; the result register lets a new request
// transfer while the previous result still waits on rsp_stall. After reset
// the metadata RAM is swept to zero, one key per cycle, during which
// req_stall is high; CSR writes are taken at any time (csr_ready is tied
// high) but must only be issued while the block is idle. Keys of NUM_KEYS
// or above change nothing and return allowed = 0, log_count = 0.
`default_nettype none

module keyed_sliding_window_rate_limiter_top #(
   parameter int NUM_KEYS = 16,
   parameter int MAX_LOG  = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire ksw_pkg::req_type             req_data,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output ksw_pkg::rsp_type                  rsp_data,
   // register write channel
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [ksw_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                  csr_wdata
);

   import ksw_pkg::*;

   localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int SLOT_W = (MAX_LOG > 1) ? $clog2(MAX_LOG) : 1;
   localparam int CNT_W  = $clog2(MAX_LOG + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int LIM_W  = (CNT_W > 4) ? CNT_W : 4;
   localparam int META_W = CNT_W + SLOT_W;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [3:0]  max_req_ff;
   logic [30:0] window_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_req_ff <= RST_MAX_REQUESTS;
         window_ff  <= RST_WINDOW_LENGTH;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_REQUESTS:  max_req_ff <= csr_wdata[3:0];
            CSR_WINDOW_LENGTH: window_ff  <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [KEY_W-1:0]    init_ptr_ff, init_ptr_in;
   req_type             item_ff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   logic                req_xfer;
   logic                rsp_xfer;
   logic                rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // key index resized to the RAM address width
   logic [KEY_W+3:0]    key_ext;
   logic [KEY_W-1:0]    key_idx;
   logic                key_ok;

   assign key_ext = {{KEY_W{1'b0}}, item_ff.key_index};
   assign key_idx = key_ext[KEY_W-1:0];
   assign key_ok  = (32'(item_ff.key_index) < NUM_KEYS);

   // ---------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------
   logic                      meta_we;
   logic [KEY_W-1:0]          meta_waddr;
   logic [META_W-1:0]         meta_wdata;
   logic [META_W-1:0]         meta_rdata;

   logic                      stamp_we;
   logic [SLOT_W-1:0]         stamp_wslot;
   logic [31:0]               stamp_rdata;

   ksw_ram #(
      .ADDR_W (KEY_W),
      .WIDTH  (META_W)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_waddr),
      .wr_data (meta_wdata),
      .rd_addr (key_idx),
      .rd_data (meta_rdata)
   );

   ksw_ram #(
      .ADDR_W (KEY_W + SLOT_W),
      .WIDTH  (32)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr ({key_idx, stamp_wslot}),
      .wr_data (item_ff.now_time),
      .rd_addr ({key_idx, slot_ff}),
      .rd_data (stamp_rdata)
   );

   // ---------------------------------------------------------------
   // Shared age unit: modulo-2^32 age, compared against the window
   // ---------------------------------------------------------------
   logic [31:0] age;
   logic        expired;

   assign age     = item_ff.now_time - stamp_rdata;
   assign expired = (age > {1'b0, window_ff});

   // effective limit and append slot
   logic [LIM_W-1:0]  limit;
   logic [LIM_W-1:0]  max_req_ext;
   logic              has_room;
   logic [SUM_W-1:0]  app_sum;
   logic [SLOT_W-1:0] slot_next;
   logic [CNT_W+3:0]  cnt_ext;

   assign max_req_ext = LIM_W'(max_req_ff);
   assign limit       = (max_req_ext > LIM_W'(MAX_LOG)) ? LIM_W'(MAX_LOG) : max_req_ext;
   assign has_room    = (LIM_W'(cnt_ff) < limit);
   assign app_sum     = SUM_W'(slot_ff) + SUM_W'(cnt_ff);
   assign stamp_wslot = (app_sum >= SUM_W'(MAX_LOG))
                        ? SLOT_W'(app_sum - SUM_W'(MAX_LOG)) : SLOT_W'(app_sum);
   assign slot_next   = (slot_ff == SLOT_W'(MAX_LOG - 1)) ? '0 : slot_ff + 1'b1;

   // ---------------------------------------------------------------
   // Next state and datapath control
   // ---------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      init_ptr_in = init_ptr_ff;
      cnt_in      = cnt_ff;
      slot_in     = slot_ff;
      res_in      = res_ff;
      meta_we     = 1'b0;
      meta_waddr  = key_idx;
      meta_wdata  = '0;
      stamp_we    = 1'b0;
      rsp_load    = 1'b0;
      cnt_ext     = '0;

      unique case (state_ff)
         ST_INIT: begin
            meta_we     = 1'b1;
            meta_waddr  = init_ptr_ff;
            init_ptr_in = init_ptr_ff + 1'b1;
            if (init_ptr_ff == KEY_W'(NUM_KEYS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_LOAD;   // metadata read in flight
         end
         ST_LOAD: begin
            res_in = '0;
            if (!key_ok) begin
               state_in = ST_DONE;
            end else if (item_ff.operation == OP_CLEAR) begin
               meta_we  = 1'b1;
               state_in = ST_DONE;
            end else begin
               {cnt_in, slot_in} = meta_rdata;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = (cnt_ff == '0) ? ST_DECIDE : ST_AGE;
         end
         ST_AGE: begin
            if (expired) begin
               slot_in  = slot_next;
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_READ;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (has_room) begin
               stamp_we = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
            meta_we        = 1'b1;
            meta_wdata     = {cnt_in, slot_ff};
            cnt_ext        = {4'b0, cnt_in};
            res_in.allowed   = has_room;
            res_in.log_count = cnt_ext[3:0];
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         init_ptr_ff <= init_ptr_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
      cnt_ff  <= cnt_in;
      slot_ff <= slot_in;
      res_ff  <= res_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // an age compare is only ever done on a live entry
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AGE |-> cnt_ff != '0)
      else $error("age compare with empty log");

   // log walk stays within the circular buffer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AGE || state_ff == ST_DECIDE) |-> 32'(slot_ff) < MAX_LOG)
      else $error("oldest slot out of range");

   // the count never exceeds the log depth while deciding
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> 32'(cnt_ff) <= MAX_LOG)
      else $error("entry count above log depth");

   // a stamp append only happens below the effective limit
   assert property (@(posedge clock) disable iff (reset)
      stamp_we |-> (state_ff == ST_DECIDE && LIM_W'(cnt_ff) < limit))
      else $error("stamp written without room");

endmodule : keyed_sliding_window_rate_limiter_top

`default_nettype wire
